[rtl/kse_pkg.sv]
// Types and constants shared by the keypad scan/edge encoder and its channel interfaces.
// No dependencies.
`default_nettype none

package kse_pkg;

   localparam int COL_WIDTH   = 4;
   localparam int ROW_COUNT   = 4;
   localparam int MAP_WIDTH   = 16;
   localparam int ASCII_WIDTH = 7;
   localparam int CSR_WIDTH   = 20;
   localparam int CSR_IDX_W   = 2;

   typedef logic [COL_WIDTH-1:0]   nibble_type;
   typedef logic [MAP_WIDTH-1:0]   key_map_type;
   typedef logic [ASCII_WIDTH-1:0] ascii_type;
   typedef logic [CSR_WIDTH-1:0]   csr_data_type;
   typedef logic [CSR_IDX_W-1:0]   csr_index_type;

   // Register indexes
   localparam csr_index_type CSR_SETTLE_TICKS = 2'd0;
   localparam csr_index_type CSR_GAP_TICKS    = 2'd1;
   localparam csr_index_type CSR_EDGE_MODE    = 2'd2;

   localparam csr_data_type SETTLE_RESET = 20'd100;
   localparam csr_data_type GAP_RESET    = 20'd10000;

   // Scan phase codes
   localparam logic [1:0] PH_FIRST  = 2'd0;
   localparam logic [1:0] PH_GAP    = 2'd1;
   localparam logic [1:0] PH_SECOND = 2'd2;

   localparam nibble_type ROW_IDLE = 4'hF;

   localparam nibble_type ROW_PATTERNS [ROW_COUNT] = '{4'h7, 4'hB, 4'hD, 4'hE};

   localparam ascii_type KEY_LABELS [MAP_WIDTH] = '{
      7'h31, 7'h32, 7'h33, 7'h41,   // 1 2 3 A
      7'h34, 7'h35, 7'h36, 7'h42,   // 4 5 6 B
      7'h37, 7'h38, 7'h39, 7'h43,   // 7 8 9 C
      7'h2A, 7'h30, 7'h23, 7'h44    // * 0 # D
   };

   // Label of the lowest set key, 0 when none
   function automatic ascii_type key_ascii_of(input key_map_type mask);
      ascii_type result;
      result = '0;
      for (int i = MAP_WIDTH - 1; i >= 0; i--) begin
         if (mask[i]) begin
            result = KEY_LABELS[i];
         end
      end
      return result;
   endfunction

endpackage

`default_nettype wire

[rtl/kse_if.sv]
// Valid/ready channel interfaces for the keypad scan/edge encoder.
// Depends on kse_pkg.
`default_nettype none

interface kse_req_if import kse_pkg::*; ();
   logic       valid;
   logic       ready;
   nibble_type column_lines;

   modport source (output valid, output column_lines, input ready);
   modport sink   (input valid, input column_lines, output ready);
endinterface

interface kse_rsp_if import kse_pkg::*; ();
   logic        valid;
   logic        ready;
   nibble_type  row_drive;
   logic        report_valid;
   key_map_type key_mask;
   ascii_type   key_ascii;

   modport source (output valid, output row_drive, output report_valid,
                   output key_mask, output key_ascii, input ready);
   modport sink   (input valid, input row_drive, input report_valid,
                   input key_mask, input key_ascii, output ready);
endinterface

`default_nettype wire

[rtl/keypad_scan_edge_encoder_unit.sv]
// 4x4 keypad scanner with plain or debounced rising-edge key reports, one tick per beat.
// Depends on kse_pkg and the channel interfaces in kse_if.sv.
//
// Every req beat is one scan tick carrying the sampled active-low column lines; every
// req beat yields exactly one rsp beat with the row pattern applied on that tick and,
// when a scan report completes, the key map and the ASCII label of its lowest key.
// One beat per cycle is sustained with rsp ready: the scan state updates as the beat
// is taken and the result lands in a single output register, which is refilled while
// its previous beat is being taken. A row lasts settle_ticks + 1 beats; edge mode adds
// gap_ticks beats between its two scans. Write the CSRs only while no beat is in flight.
`default_nettype none

module keypad_scan_edge_encoder_unit import kse_pkg::*; #(
   parameter int TIMER_WIDTH = 20
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          csr_write_en,
   input  wire csr_index_type csr_index,
   input  wire csr_data_type  csr_wdata,
   kse_req_if.sink            req_chan,
   kse_rsp_if.source          rsp_chan
);

   localparam int LW = (TIMER_WIDTH > CSR_WIDTH) ? TIMER_WIDTH : CSR_WIDTH;
   localparam logic [LW-1:0] TIMER_MAX = LW'({TIMER_WIDTH{1'b1}});

   typedef logic [TIMER_WIDTH-1:0] timer_type;

   csr_data_type settle_ticks_ff, gap_ticks_ff;
   logic         edge_mode_ff;

   logic [1:0]  row_index_ff, row_index_in;
   timer_type   wait_counter_ff, wait_counter_in;
   logic [1:0]  scan_phase_ff, scan_phase_in;
   key_map_type scan_accum_ff, scan_accum_in;
   key_map_type first_scan_ff, first_scan_in;
   key_map_type previous_keys_ff, previous_keys_in;

   logic        rsp_valid_ff;
   nibble_type  row_drive_ff, row_drive_in;
   logic        report_valid_ff, report_valid_in;
   key_map_type key_mask_ff, key_mask_in;
   ascii_type   key_ascii_ff;

   logic        req_take;
   logic [LW-1:0] settle_ext, gap_ext;
   timer_type   settle_lim, gap_lim;
   key_map_type accum_new, both_scans;

   // CSRs
   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ticks_ff <= SETTLE_RESET;
         gap_ticks_ff    <= GAP_RESET;
         edge_mode_ff    <= 1'b0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_SETTLE_TICKS: settle_ticks_ff <= csr_wdata;
            CSR_GAP_TICKS:    gap_ticks_ff    <= csr_wdata;
            CSR_EDGE_MODE:    edge_mode_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Limits clamp to the timer range
   always_comb begin
      settle_ext = LW'(settle_ticks_ff);
      gap_ext    = LW'(gap_ticks_ff);
      settle_lim = TIMER_WIDTH'((settle_ext > TIMER_MAX) ? TIMER_MAX : settle_ext);
      gap_lim    = TIMER_WIDTH'((gap_ext > TIMER_MAX) ? TIMER_MAX : gap_ext);
   end

   assign req_take       = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;

   // One scan tick
   always_comb begin
      row_index_in     = row_index_ff;
      wait_counter_in  = wait_counter_ff;
      scan_phase_in    = scan_phase_ff;
      scan_accum_in    = scan_accum_ff;
      first_scan_in    = first_scan_ff;
      previous_keys_in = previous_keys_ff;
      row_drive_in     = ROW_IDLE;
      report_valid_in  = 1'b0;
      key_mask_in      = '0;

      accum_new = scan_accum_ff;
      accum_new[{row_index_ff, 2'b00} +: COL_WIDTH] =
         scan_accum_ff[{row_index_ff, 2'b00} +: COL_WIDTH] | ~req_chan.column_lines;
      both_scans = first_scan_ff & accum_new;

      if (scan_phase_ff == PH_GAP) begin
         if (wait_counter_ff >= gap_lim) begin
            scan_phase_in   = PH_SECOND;
            wait_counter_in = '0;
         end else begin
            wait_counter_in = wait_counter_ff + 1'b1;
         end
      end else begin
         row_drive_in = ROW_PATTERNS[row_index_ff];
         if (wait_counter_ff < settle_lim) begin
            wait_counter_in = wait_counter_ff + 1'b1;
         end else begin
            wait_counter_in = '0;
            if (row_index_ff != 2'd3) begin
               row_index_in  = row_index_ff + 2'd1;
               scan_accum_in = accum_new;
            end else begin
               row_index_in  = 2'd0;
               scan_accum_in = '0;
               if (!edge_mode_ff) begin
                  report_valid_in = 1'b1;
                  key_mask_in     = accum_new;
                  scan_phase_in   = PH_FIRST;
               end else if (scan_phase_ff != PH_SECOND) begin
                  first_scan_in = accum_new;
                  if (gap_lim == '0) begin
                     scan_phase_in = PH_SECOND;
                  end else begin
                     scan_phase_in   = PH_GAP;
                     wait_counter_in = TIMER_WIDTH'(1);
                  end
               end else begin
                  key_mask_in      = both_scans & ~previous_keys_ff;
                  previous_keys_in = both_scans;
                  report_valid_in  = 1'b1;
                  scan_phase_in    = PH_FIRST;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_index_ff     <= '0;
         wait_counter_ff  <= '0;
         scan_phase_ff    <= PH_FIRST;
         scan_accum_ff    <= '0;
         first_scan_ff    <= '0;
         previous_keys_ff <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (req_take) begin
            row_index_ff     <= row_index_in;
            wait_counter_ff  <= wait_counter_in;
            scan_phase_ff    <= scan_phase_in;
            scan_accum_ff    <= scan_accum_in;
            first_scan_ff    <= first_scan_in;
            previous_keys_ff <= previous_keys_in;
            rsp_valid_ff     <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff     <= 1'b0;
         end
      end
   end

   // Result register, payload only
   always_ff @(posedge clock) begin
      if (req_take) begin
         row_drive_ff    <= row_drive_in;
         report_valid_ff <= report_valid_in;
         key_mask_ff     <= key_mask_in;
         key_ascii_ff    <= key_ascii_of(key_mask_in);
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.row_drive    = row_drive_ff;
   assign rsp_chan.report_valid = report_valid_ff;
   assign rsp_chan.key_mask     = key_mask_ff;
   assign rsp_chan.key_ascii    = key_ascii_ff;

endmodule

`default_nettype wire
